### design/mm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared sizes, codes and the control interface types of the matrix
// multiplier.
// ----------------------------------------------------------------------------
package mm_pkg;

   localparam int MAX_DIM     = 8;
   localparam int ELEM_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int RESULT_W    = 40;
   localparam int CFG_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int DIM_RESET_RAW = 8;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B     = CSR_IDX_W'(2);

   localparam logic KIND_LEFT  = 1'b0;
   localparam logic KIND_RIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] n;
      logic [DIM_W-1:0] p;
   } dims_type;

   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_valid;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              first;
      logic              sum_last;
      logic              final_elem;
   } cmd_type;

   typedef struct packed {
      logic final_done;
   } sts_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic sum_last;
      logic final_elem;
   } tag_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw);
      logic [DIM_W-1:0] res;
      if (raw == CFG_W'(0)) begin
         res = DIM_W'(1);
      end else if (32'(raw) > MAX_DIM) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = DIM_W'(raw);
      end
      return res;
   endfunction

   localparam logic [DIM_W-1:0] DIM_RESET = clamp_dim(CFG_W'(DIM_RESET_RAW));

endpackage

### design/matrix_multiply.sv
// ----------------------------------------------------------------------------
// Matrix multiply
// Dense product C = A x B of signed Q8.8 matrices with exact Q24.16 results.
// ----------------------------------------------------------------------------
// Elements are loaded one beat per cycle while the block is idle, A in
// row-major order and then B, each tagged by req_kind; surplus elements of a
// complete matrix are dropped. Once the beat that completes both matrices is
// registered, busy rises and stays high while the block computes: one
// multiply-accumulate per cycle through a single shared multiplier. Each
// element of C appears for one cycle with rsp_strobe high, and the last one
// carries rsp_last_element. The receiver cannot stall the block; every
// result must be captured on its strobe. The user must write dimensions on
// the csr port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module matrix_multiply (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic signed [mm_pkg::ELEM_W-1:0]    req_element_value,
   output logic                                rsp_strobe,
   output logic signed [mm_pkg::RESULT_W-1:0]  rsp_product_value,
   output logic                                rsp_last_element,
   input  logic                                csr_write_enable,
   input  logic [mm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mm_pkg::CFG_W-1:0]            csr_write_data
);
   import mm_pkg::*;

   dims_type dims;
   cmd_type  cmd;
   sts_type  sts;

   mm_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .dims             (dims)
   );

   mm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .dims     (dims),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   mm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_value (req_element_value),
      .sts               (sts),
      .rsp_strobe        (rsp_strobe),
      .rsp_product_value (rsp_product_value),
      .rsp_last_element  (rsp_last_element)
   );

endmodule

### design/mm_config.sv
// ----------------------------------------------------------------------------
// Matrix multiply configuration registers
// Holds the three dimensions, limited to the supported range when written.
// ----------------------------------------------------------------------------
module mm_config (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [mm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mm_pkg::CFG_W-1:0]      csr_write_data,
   output mm_pkg::dims_type              dims
);
   import mm_pkg::*;

   dims_type dims_ff;
   dims_type dims_in;

   always_comb begin
      dims_in = dims_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_ROWS_A:     dims_in.m = clamp_dim(csr_write_data);
            REG_INNER_SIZE: dims_in.n = clamp_dim(csr_write_data);
            REG_COLS_B:     dims_in.p = clamp_dim(csr_write_data);
            default:        dims_in = dims_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.m <= DIM_RESET;
         dims_ff.n <= DIM_RESET;
         dims_ff.p <= DIM_RESET;
      end else begin
         dims_ff <= dims_in;
      end
   end

   assign dims = dims_ff;

endmodule

### design/mm_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Counts loaded elements, detects a complete pair of matrices and steps the
// row, column and inner indexes that drive the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module mm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_kind,
   input  mm_pkg::dims_type  dims,
   input  mm_pkg::sts_type   sts,
   output logic              busy,
   output mm_pkg::cmd_type   cmd
);
   import mm_pkg::*;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  left_count_ff, left_count_in;
   logic [COUNT_W-1:0]  right_count_ff, right_count_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   logic [ADDR_W-1:0]   a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]   b_addr_ff, b_addr_in;
   logic [ADDR_W-1:0]   row_base_ff, row_base_in;

   logic [COUNT_W-1:0]  need_left;
   logic [COUNT_W-1:0]  need_right;
   logic [COUNT_W-1:0]  left_next;
   logic [COUNT_W-1:0]  right_next;
   logic                accept;
   logic                left_hit;
   logic                right_hit;
   logic                k_last;
   logic                j_last;
   logic                i_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_addr_ff   <= a_addr_in;
      b_addr_ff   <= b_addr_in;
      row_base_ff <= row_base_in;
   end

   always_comb begin
      need_left  = COUNT_W'(dims.m) * COUNT_W'(dims.n);
      need_right = COUNT_W'(dims.n) * COUNT_W'(dims.p);
      k_last     = (k_ff == IDX_W'(dims.n - DIM_W'(1)));
      j_last     = (j_ff == IDX_W'(dims.p - DIM_W'(1)));
      i_last     = (i_ff == IDX_W'(dims.m - DIM_W'(1)));

      busy      = (state_ff != ST_IDLE);
      accept    = start && !busy;
      left_hit  = accept && (req_kind == KIND_LEFT) && (left_count_ff < need_left);
      right_hit = accept && (req_kind == KIND_RIGHT) && (right_count_ff < need_right);
      left_next  = left_count_ff + COUNT_W'(left_hit);
      right_next = right_count_ff + COUNT_W'(right_hit);

      state_in       = state_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      a_addr_in      = a_addr_ff;
      b_addr_in      = b_addr_ff;
      row_base_in    = row_base_ff;

      cmd            = '0;
      cmd.wr_left    = left_hit;
      cmd.wr_right   = right_hit;
      cmd.wr_addr    = left_hit ? left_count_ff[ADDR_W-1:0] : right_count_ff[ADDR_W-1:0];
      cmd.rd_addr_a  = a_addr_ff;
      cmd.rd_addr_b  = b_addr_ff;

      case (state_ff)
         ST_IDLE: begin
            left_count_in  = left_next;
            right_count_in = right_next;
            if (accept && (left_next >= need_left) && (right_next >= need_right)) begin
               left_count_in  = '0;
               right_count_in = '0;
               i_in           = '0;
               j_in           = '0;
               k_in           = '0;
               a_addr_in      = '0;
               b_addr_in      = '0;
               row_base_in    = '0;
               state_in       = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.rd_valid   = 1'b1;
            cmd.first      = (k_ff == '0);
            cmd.sum_last   = k_last;
            cmd.final_elem = k_last && j_last && i_last;
            if (!k_last) begin
               k_in      = k_ff + IDX_W'(1);
               a_addr_in = a_addr_ff + ADDR_W'(1);
               b_addr_in = b_addr_ff + ADDR_W'(dims.p);
            end else begin
               k_in = '0;
               if (!j_last) begin
                  j_in      = j_ff + IDX_W'(1);
                  a_addr_in = row_base_ff;
                  b_addr_in = ADDR_W'(j_ff) + ADDR_W'(1);
               end else begin
                  j_in      = '0;
                  b_addr_in = '0;
                  if (!i_last) begin
                     i_in        = i_ff + IDX_W'(1);
                     row_base_in = row_base_ff + ADDR_W'(dims.n);
                     a_addr_in   = row_base_ff + ADDR_W'(dims.n);
                  end else begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (sts.final_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/mm_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores for both matrices, a registered multiplier and the
// accumulator that forms and presents each result element.
// ----------------------------------------------------------------------------
module mm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mm_pkg::cmd_type                     cmd,
   input  logic signed [mm_pkg::ELEM_W-1:0]    req_element_value,
   output mm_pkg::sts_type                     sts,
   output logic                                rsp_strobe,
   output logic signed [mm_pkg::RESULT_W-1:0]  rsp_product_value,
   output logic                                rsp_last_element
);
   import mm_pkg::*;

   logic signed [ELEM_W-1:0]   left_mem [STORE_DEPTH];
   logic signed [ELEM_W-1:0]   right_mem [STORE_DEPTH];

   logic signed [ELEM_W-1:0]   left_q_ff;
   logic signed [ELEM_W-1:0]   right_q_ff;
   logic signed [PROD_W-1:0]   product_ff;
   logic signed [RESULT_W-1:0] acc_ff, acc_in;
   logic signed [RESULT_W-1:0] value_ff;
   logic                       last_ff;
   logic                       strobe_ff;
   tag_type                    tag1_ff, tag1_in;
   tag_type                    tag2_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[cmd.wr_addr] <= req_element_value;
      end
      if (cmd.wr_right) begin
         right_mem[cmd.wr_addr] <= req_element_value;
      end
      left_q_ff  <= left_mem[cmd.rd_addr_a];
      right_q_ff <= right_mem[cmd.rd_addr_b];
   end

   always_comb begin
      tag1_in.valid      = cmd.rd_valid;
      tag1_in.first      = cmd.first;
      tag1_in.sum_last   = cmd.sum_last;
      tag1_in.final_elem = cmd.final_elem;
      if (tag2_ff.first) begin
         acc_in = RESULT_W'(product_ff);
      end else begin
         acc_in = acc_ff + RESULT_W'(product_ff);
      end
      sts.final_done = tag2_ff.valid && tag2_ff.final_elem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff   <= '0;
         tag2_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         tag1_ff   <= tag1_in;
         tag2_ff   <= tag1_ff;
         strobe_ff <= tag2_ff.valid && tag2_ff.sum_last;
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= left_q_ff * right_q_ff;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (tag2_ff.valid && tag2_ff.sum_last) begin
         value_ff <= acc_in;
         last_ff  <= tag2_ff.final_elem;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_product_value = value_ff;
   assign rsp_last_element  = last_ff;

endmodule
